// ----- rtl/core/pcpt_pkg.sv -----
// Shared widths, register codes and reset values for the parabolic cylinder point transform.
package pcpt_pkg;

   localparam int ParamW   = 17;  // param_u, param_v: unsigned Q1.16
   localparam int CenterW  = 18;  // centered parameter, signed
   localparam int SquareW  = 34;  // u'*u', never negative
   localparam int CurvW    = 24;  // curvature, signed Q8.16
   localparam int CoefW    = 16;  // one Q8.8 scale or Q2.14 matrix entry
   localparam int CurvProdW = 59; // u'^2 * curvature, signed
   localparam int YW       = 27;  // Y term in Q16.16, signed
   localparam int PxzW     = 34;  // scaled X and Z, Q.24 signed
   localparam int PyW      = 43;  // scaled Y, Q.24 signed
   localparam int TermW    = 59;  // one row product, Q.38 signed
   localparam int SumW     = 61;  // sum of three row products
   localparam int RndW     = 39;  // rounded row sum, Q16.16 signed
   localparam int CoordW   = 32;  // output coordinate / offset
   localparam int PackW    = 48;  // packed triple register
   localparam int CsrIdxW  = 3;

   localparam logic [CsrIdxW-1:0] CSR_CURVATURE   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_AXIS_SCALES = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ROT_ROW_X   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ROT_ROW_Y   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_ROT_ROW_Z   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_X    = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_Y    = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET_Z    = 3'd7;

   localparam logic [CurvW-1:0] CURV_RESET   = 24'h00_4000;
   localparam logic [PackW-1:0] SCALE_RESET  = 48'h0100_0100_0100;
   localparam logic [PackW-1:0] ROW_X_RESET  = 48'h0000_0000_4000;
   localparam logic [PackW-1:0] ROW_Y_RESET  = 48'h0000_4000_0000;
   localparam logic [PackW-1:0] ROW_Z_RESET  = 48'h4000_0000_0000;

   localparam logic [CenterW-1:0] HALF_Q16 = 18'd32768;

   typedef logic signed [CoordW-1:0] coord_type;

endpackage

// ----- rtl/core/pcpt_row.sv -----
// One output coordinate: three products with a matrix row, rounding, offset, saturation.
module pcpt_row
   import pcpt_pkg::*;
(
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [PxzW-1:0]   p_x,
   input  logic signed [PyW-1:0]    p_y,
   input  logic signed [PxzW-1:0]   p_z,
   input  logic        [PackW-1:0]  row,
   input  logic        [CoordW-1:0] offset,
   output coord_type                point
);

   logic signed [TermW-1:0]  term0_ff, term1_ff, term2_ff;
   logic signed [TermW-1:0]  term0_in, term1_in, term2_in;
   logic signed [SumW-1:0]   sum_in;
   logic signed [RndW-1:0]   rnd_ff, rnd_in;
   logic signed [RndW:0]     shifted;
   coord_type                point_ff, point_in;

   // products, Q.38
   always_comb begin
      term0_in = TermW'($signed(PyW'(p_x)) * $signed(row[15:0]));
      term1_in = TermW'(p_y * $signed(row[31:16]));
      term2_in = TermW'($signed(PyW'(p_z)) * $signed(row[47:32]));
   end

   // exact sum, then round to nearest with ties up
   always_comb begin
      sum_in = SumW'(term0_ff) + SumW'(term1_ff) + SumW'(term2_ff)
               + SumW'(64'sd1 <<< 21);
      rnd_in = sum_in[SumW-1:22];
   end

   // add offset and clamp to 32 bits
   always_comb begin
      shifted = (RndW+1)'(rnd_ff) + (RndW+1)'($signed(offset));
      if (shifted > (RndW+1)'(64'sd2147483647))
         point_in = 32'sh7FFF_FFFF;
      else if (shifted < (RndW+1)'(-64'sd2147483648))
         point_in = 32'sh8000_0000;
      else
         point_in = shifted[CoordW-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term0_ff <= term0_in;
         term1_ff <= term1_in;
         term2_ff <= term2_in;
         rnd_ff   <= rnd_in;
         point_ff <= point_in;
      end
   end

   assign point = point_ff;

endmodule

// ----- rtl/core/parabolic_cylinder_point_transform_unit.sv -----
// Top level: parabolic cylinder surface point with scale, rotation and translation.
// Six register stages lie between req item accept and rsp item valid
// (center and square, curvature product, Y rounding and scaling, row products,
// row sum and rounding, offset and saturation).
// Throughput: one item per cycle; the whole pipe holds while a finished item waits.
// Reset: synchronous, active high; empties the pipe and loads the register defaults.
module parabolic_cylinder_point_transform_unit
   import pcpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request items
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [39:0]         req_tdata,   // param_u [16:0], param_v [33:17], zero [39:34]
   // result items
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [95:0]         rsp_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
   // register writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [PackW-1:0]    csr_data
);

   localparam int Depth = 6;

   // ---------------------------------------------------------------- registers
   logic [CurvW-1:0]  curv_ff;
   logic [PackW-1:0]  scale_ff, row_x_ff, row_y_ff, row_z_ff;
   logic [CoordW-1:0] off_x_ff, off_y_ff, off_z_ff;

   // The user must write only while the pipe is idle (the block does not enforce this); the stages read these directly.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         curv_ff  <= CURV_RESET;
         scale_ff <= SCALE_RESET;
         row_x_ff <= ROW_X_RESET;
         row_y_ff <= ROW_Y_RESET;
         row_z_ff <= ROW_Z_RESET;
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CURVATURE:   curv_ff  <= csr_data[CurvW-1:0];
            CSR_AXIS_SCALES: scale_ff <= csr_data;
            CSR_ROT_ROW_X:   row_x_ff <= csr_data;
            CSR_ROT_ROW_Y:   row_y_ff <= csr_data;
            CSR_ROT_ROW_Z:   row_z_ff <= csr_data;
            CSR_OFFSET_X:    off_x_ff <= csr_data[CoordW-1:0];
            CSR_OFFSET_Y:    off_y_ff <= csr_data[CoordW-1:0];
            CSR_OFFSET_Z:    off_z_ff <= csr_data[CoordW-1:0];
            default:         ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Advance every stage together unless the output item is stalled.
   logic [Depth-1:0] vld_ff, vld_in;
   logic             advance;

   assign advance    = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[Depth-1];
   assign vld_in     = {vld_ff[Depth-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (advance)
         vld_ff <= vld_in;
   end

   // ---------------------------------------------------------------- stage 1
   // Center both parameters on one half and square u'.
   logic [ParamW-1:0]          param_u, param_v;
   logic signed [CenterW-1:0]  u_in, v_in, u1_ff, v1_ff;
   logic signed [2*CenterW-1:0] uu_full;
   logic [SquareW-1:0]         uu_ff, uu_in;

   assign param_u = req_tdata[ParamW-1:0];
   assign param_v = req_tdata[2*ParamW-1:ParamW];

   always_comb begin
      u_in    = $signed({1'b0, param_u}) - $signed(HALF_Q16);
      v_in    = $signed({1'b0, param_v}) - $signed(HALF_Q16);
      uu_full = u_in * u_in;
      uu_in   = uu_full[SquareW-1:0];
   end

   // ---------------------------------------------------------------- stage 2
   // Multiply by curvature; scale X and Z.
   logic signed [CurvProdW-1:0] cprod_ff, cprod_in;
   logic signed [PxzW-1:0]      px2_ff, pz2_ff, px_in, pz_in;

   always_comb begin
      cprod_in = CurvProdW'($signed({1'b0, uu_ff}) * $signed(curv_ff));
      px_in    = PxzW'(u1_ff * $signed(scale_ff[15:0]));
      pz_in    = PxzW'(v1_ff * $signed(scale_ff[47:32]));
   end

   // ---------------------------------------------------------------- stage 3
   // Round the Y term to Q16.16 (ties up) and scale it.
   logic signed [CurvProdW-1:0] cround;
   logic signed [YW-1:0]        y0;
   logic signed [PyW-1:0]       py3_ff, py_in;
   logic signed [PxzW-1:0]      px3_ff, pz3_ff;

   always_comb begin
      cround = cprod_ff + CurvProdW'(64'sd1 <<< 31);
      y0     = cround[CurvProdW-1:32];
      py_in  = PyW'(y0 * $signed(scale_ff[31:16]));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u1_ff    <= u_in;
         v1_ff    <= v_in;
         uu_ff    <= uu_in;
         cprod_ff <= cprod_in;
         px2_ff   <= px_in;
         pz2_ff   <= pz_in;
         py3_ff   <= py_in;
         px3_ff   <= px2_ff;
         pz3_ff   <= pz2_ff;
      end
   end

   // ---------------------------------------------------------------- stages 4..6
   // Each row: products, rounded sum, offset and saturation.
   coord_type point_x, point_y, point_z;

   pcpt_row u_row_x (
      .clock   (clock),
      .advance (advance),
      .p_x     (px3_ff),
      .p_y     (py3_ff),
      .p_z     (pz3_ff),
      .row     (row_x_ff),
      .offset  (off_x_ff),
      .point   (point_x)
   );

   pcpt_row u_row_y (
      .clock   (clock),
      .advance (advance),
      .p_x     (px3_ff),
      .p_y     (py3_ff),
      .p_z     (pz3_ff),
      .row     (row_y_ff),
      .offset  (off_y_ff),
      .point   (point_y)
   );

   pcpt_row u_row_z (
      .clock   (clock),
      .advance (advance),
      .p_x     (px3_ff),
      .p_y     (py3_ff),
      .p_z     (pz3_ff),
      .row     (row_z_ff),
      .offset  (off_z_ff),
      .point   (point_z)
   );

   assign rsp_tdata = {point_z, point_y, point_x};

endmodule
